/* src/sbr_pkg.sv */
// Shared types and constants for the stack blur frame store.
// Used by every module of the block but sbr_ram; depends on nothing.
package sbr_pkg;

   localparam int PIX_W = 32;
   localparam int CHAN_N = 4;
   localparam int SUM_W = 24;
   localparam int EDGE_W = 16;
   localparam int DIVR_W = 16;
   localparam int RAD_W = 8;
   localparam int TAP_W = 9;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_RUN = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [1:0] CSR_WIDTH = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_INIT,
      OP_TAKE_A,
      OP_TAKE_B,
      OP_TAKE_C
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rd_en;
      logic      wr_en;
      logic      cols;
      logic      to_in;
      logic      div_start;
   } dp_cmd_type;

endpackage

/* src/sbr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sbr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sbr_div.sv */
// Four-lane restoring divider producing an 8-bit quotient, one bit per cycle.
// Depends on sbr_pkg.
module sbr_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sbr_pkg::SUM_W-1:0]  dividend [sbr_pkg::CHAN_N],
   input  logic [sbr_pkg::DIVR_W-1:0] divisor,
   output logic [7:0]                 quotient [sbr_pkg::CHAN_N],
   output logic                       done
);

   logic [sbr_pkg::SUM_W-1:0] rem_ff [sbr_pkg::CHAN_N];
   logic [sbr_pkg::SUM_W-1:0] rem_in [sbr_pkg::CHAN_N];
   logic [7:0]                quo_ff [sbr_pkg::CHAN_N];
   logic [7:0]                quo_in [sbr_pkg::CHAN_N];
   logic [2:0]                bit_ff;
   logic                      run_ff;
   logic                      done_ff;
   logic [sbr_pkg::SUM_W:0]   shifted;
   logic [sbr_pkg::SUM_W:0]   trial [sbr_pkg::CHAN_N];

   always_comb begin
      shifted = (sbr_pkg::SUM_W + 1)'(divisor) << bit_ff;
      for (int c = 0; c < sbr_pkg::CHAN_N; c++) begin
         trial[c] = {1'b0, rem_ff[c]} - shifted;
         rem_in[c] = rem_ff[c];
         quo_in[c] = quo_ff[c];
         if (!trial[c][sbr_pkg::SUM_W]) begin
            rem_in[c] = trial[c][sbr_pkg::SUM_W-1:0];
            quo_in[c][bit_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         bit_ff <= 3'd7;
      end else if (start) begin
         run_ff <= 1'b1;
         done_ff <= 1'b0;
         bit_ff <= 3'd7;
      end else if (run_ff) begin
         bit_ff <= bit_ff - 3'd1;
         if (bit_ff == 3'd0) begin
            run_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < sbr_pkg::CHAN_N; c++) begin
         if (start) begin
            rem_ff[c] <= dividend[c];
            quo_ff[c] <= 8'd0;
         end else if (run_ff) begin
            rem_ff[c] <= rem_in[c];
            quo_ff[c] <= quo_in[c];
         end
      end
   end

   assign quotient = quo_ff;
   assign done = done_ff;

endmodule

/* src/sbr_ctrl.sv */
// Sequencer for the blur run: walks passes, lines, window taps and pixels.
// Depends on sbr_pkg; drives the datapath by command struct.
module sbr_ctrl #(
   parameter int LW = 9,
   parameter int WW = 9,
   parameter int HW = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [WW-1:0]             eff_w,
   input  logic [HW-1:0]             eff_h,
   input  logic [sbr_pkg::RAD_W-1:0] eff_r,
   input  logic                      div_done,
   output logic                      busy,
   output sbr_pkg::dp_cmd_type       cmd,
   output logic [LW-1:0]             pos,
   output logic [LW-1:0]             line,
   output logic [sbr_pkg::TAP_W-1:0] wgt
);

   localparam int TW = ((LW > sbr_pkg::TAP_W) ? LW : sbr_pkg::TAP_W) + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_LINE, S_INIT_RD, S_INIT_ACC, S_DIV, S_DIV_WAIT,
      S_WRITE, S_RD_A, S_GET_A, S_GET_B, S_GET_C
   } state_type;

   state_type                 state_ff;
   logic                      cols_ff;
   logic [LW-1:0]             line_ff;
   logic [LW-1:0]             k_ff;
   logic [sbr_pkg::TAP_W-1:0] i_ff;
   logic [sbr_pkg::RAD_W-1:0] r_ff;

   logic [TW-1:0] n_last;
   logic [TW-1:0] lines_last;
   logic [TW-1:0] r_ext;
   logic [TW-1:0] i_ext;
   logic [TW-1:0] k_ext;
   logic [TW-1:0] t_val;
   logic [TW-1:0] span;

   always_comb begin
      r_ext = TW'(r_ff);
      i_ext = TW'(i_ff);
      k_ext = TW'(k_ff);
      span = (r_ext << 1) + TW'(1);
      n_last = cols_ff ? TW'(eff_h) - TW'(1) : TW'(eff_w) - TW'(1);
      lines_last = cols_ff ? TW'(eff_w) - TW'(1) : TW'(eff_h) - TW'(1);
      cmd = '{op: sbr_pkg::OP_NONE, rd_en: 1'b0, wr_en: 1'b0, cols: cols_ff,
              to_in: (i_ff > sbr_pkg::TAP_W'(r_ff)), div_start: 1'b0};
      t_val = '0;
      wgt = (i_ext < r_ext) ? sbr_pkg::TAP_W'(i_ext + TW'(1))
                            : sbr_pkg::TAP_W'(span - i_ext);
      unique case (state_ff)
         S_IDLE: ;
         S_LINE: cmd.op = sbr_pkg::OP_CLEAR;
         S_INIT_RD: begin
            cmd.rd_en = 1'b1;
            t_val = (i_ext < r_ext) ? '0 : i_ext - r_ext;
         end
         S_INIT_ACC: cmd.op = sbr_pkg::OP_INIT;
         S_DIV: cmd.div_start = 1'b1;
         S_DIV_WAIT: ;
         S_WRITE: begin
            cmd.wr_en = 1'b1;
            t_val = k_ext;
         end
         S_RD_A: begin
            cmd.rd_en = 1'b1;
            t_val = (k_ext < r_ext) ? '0 : k_ext - r_ext;
         end
         S_GET_A: begin
            cmd.op = sbr_pkg::OP_TAKE_A;
            cmd.rd_en = 1'b1;
            t_val = k_ext + r_ext + TW'(1);
         end
         S_GET_B: begin
            cmd.op = sbr_pkg::OP_TAKE_B;
            cmd.rd_en = 1'b1;
            t_val = k_ext + TW'(1);
         end
         S_GET_C: cmd.op = sbr_pkg::OP_TAKE_C;
         default: ;
      endcase
      if (t_val > n_last) begin
         t_val = n_last;
      end
      pos = LW'(t_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cols_ff <= 1'b0;
         line_ff <= '0;
         k_ff <= '0;
         i_ff <= '0;
         r_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start && eff_r != '0) begin
                  r_ff <= eff_r;
                  cols_ff <= 1'b0;
                  line_ff <= '0;
                  state_ff <= S_LINE;
               end
            end
            S_LINE: begin
               i_ff <= '0;
               state_ff <= S_INIT_RD;
            end
            S_INIT_RD: state_ff <= S_INIT_ACC;
            S_INIT_ACC: begin
               if (i_ext == span - TW'(1)) begin
                  k_ff <= '0;
                  state_ff <= S_DIV;
               end else begin
                  i_ff <= i_ff + sbr_pkg::TAP_W'(1);
                  state_ff <= S_INIT_RD;
               end
            end
            S_DIV: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_done) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: state_ff <= S_RD_A;
            S_RD_A: state_ff <= S_GET_A;
            S_GET_A: state_ff <= S_GET_B;
            S_GET_B: state_ff <= S_GET_C;
            S_GET_C: begin
               if (k_ext == n_last) begin
                  if (TW'(line_ff) == lines_last) begin
                     line_ff <= '0;
                     if (cols_ff) begin
                        cols_ff <= 1'b0;
                        state_ff <= S_IDLE;
                     end else begin
                        cols_ff <= 1'b1;
                        state_ff <= S_LINE;
                     end
                  end else begin
                     line_ff <= line_ff + LW'(1);
                     state_ff <= S_LINE;
                  end
               end else begin
                  k_ff <= k_ff + LW'(1);
                  state_ff <= S_DIV;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign line = line_ff;

endmodule

/* src/sbr_dp.sv */
// Datapath: frame and scratch memories, running window sums and the divider.
// Depends on sbr_pkg, sbr_ram and sbr_div.
module sbr_dp #(
   parameter int LW = 9,
   parameter int WW = 9,
   parameter int AW = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sbr_pkg::dp_cmd_type       cmd,
   input  logic [LW-1:0]             pos,
   input  logic [LW-1:0]             line,
   input  logic [sbr_pkg::TAP_W-1:0] wgt,
   input  logic [WW-1:0]             eff_w,
   input  logic [sbr_pkg::RAD_W-1:0] eff_r,
   input  logic                      host_wr_en,
   input  logic [AW-1:0]             host_addr,
   input  logic [sbr_pkg::PIX_W-1:0] host_wr_data,
   output logic [sbr_pkg::PIX_W-1:0] host_rd_data,
   output logic                      div_done
);

   localparam int DEPTH = 2 ** AW;

   logic [sbr_pkg::SUM_W-1:0]  w_ff [sbr_pkg::CHAN_N];
   logic [sbr_pkg::EDGE_W-1:0] in_ff [sbr_pkg::CHAN_N];
   logic [sbr_pkg::EDGE_W-1:0] out_ff [sbr_pkg::CHAN_N];
   logic [sbr_pkg::DIVR_W-1:0] divisor_ff;
   logic [sbr_pkg::DIVR_W-1:0] divisor_in;
   logic [7:0]                 quo [sbr_pkg::CHAN_N];

   logic [LW+WW-1:0]          prod;
   logic [AW-1:0]             blur_addr;
   logic [sbr_pkg::PIX_W-1:0] img_q;
   logic [sbr_pkg::PIX_W-1:0] scr_q;
   logic [sbr_pkg::PIX_W-1:0] src_q;
   logic [sbr_pkg::PIX_W-1:0] res_pix;
   logic                      img_we;
   logic [AW-1:0]             img_waddr;
   logic [sbr_pkg::PIX_W-1:0] img_wdata;
   logic [AW-1:0]             img_raddr;
   logic [sbr_pkg::RAD_W:0]   r_plus;
   logic [2*sbr_pkg::RAD_W+1:0] r_sq;

   // Rows: line * width + pos. Columns: pos * width + line.
   always_comb begin
      prod = (LW + WW)'(cmd.cols ? pos : line) * (LW + WW)'(eff_w);
      blur_addr = AW'(prod + (LW + WW)'(cmd.cols ? line : pos));
      for (int c = 0; c < sbr_pkg::CHAN_N; c++) begin
         res_pix[8*c +: 8] = quo[c];
      end
      src_q = cmd.cols ? scr_q : img_q;
      img_we = host_wr_en | (cmd.wr_en & cmd.cols);
      img_waddr = host_wr_en ? host_addr : blur_addr;
      img_wdata = host_wr_en ? host_wr_data : res_pix;
      img_raddr = cmd.rd_en ? blur_addr : host_addr;
      r_plus = {1'b0, eff_r} + (sbr_pkg::RAD_W + 1)'(1);
      r_sq = (2 * sbr_pkg::RAD_W + 2)'(r_plus) * (2 * sbr_pkg::RAD_W + 2)'(r_plus);
      divisor_in = sbr_pkg::DIVR_W'(r_sq);
   end

   sbr_ram #(.WIDTH(sbr_pkg::PIX_W), .DEPTH(DEPTH)) u_image (
      .clock   (clock),
      .wr_en   (img_we),
      .wr_addr (img_waddr),
      .wr_data (img_wdata),
      .rd_addr (img_raddr),
      .rd_data (img_q)
   );

   sbr_ram #(.WIDTH(sbr_pkg::PIX_W), .DEPTH(DEPTH)) u_scratch (
      .clock   (clock),
      .wr_en   (cmd.wr_en & ~cmd.cols),
      .wr_addr (blur_addr),
      .wr_data (res_pix),
      .rd_addr (blur_addr),
      .rd_data (scr_q)
   );

   sbr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (w_ff),
      .divisor  (divisor_ff),
      .quotient (quo),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= sbr_pkg::DIVR_W'(1);
         for (int c = 0; c < sbr_pkg::CHAN_N; c++) begin
            w_ff[c] <= '0;
            in_ff[c] <= '0;
            out_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < sbr_pkg::CHAN_N; c++) begin
            case (cmd.op)
               sbr_pkg::OP_CLEAR: begin
                  w_ff[c] <= '0;
                  in_ff[c] <= '0;
                  out_ff[c] <= '0;
               end
               sbr_pkg::OP_INIT: begin
                  w_ff[c] <= w_ff[c] + sbr_pkg::SUM_W'(src_q[8*c +: 8])
                             * sbr_pkg::SUM_W'(wgt);
                  if (cmd.to_in) begin
                     in_ff[c] <= in_ff[c] + sbr_pkg::EDGE_W'(src_q[8*c +: 8]);
                  end else begin
                     out_ff[c] <= out_ff[c] + sbr_pkg::EDGE_W'(src_q[8*c +: 8]);
                  end
               end
               sbr_pkg::OP_TAKE_A: begin
                  // The window leaves the pixel furthest behind.
                  w_ff[c] <= w_ff[c] - sbr_pkg::SUM_W'(out_ff[c]);
                  out_ff[c] <= out_ff[c] - sbr_pkg::EDGE_W'(src_q[8*c +: 8]);
               end
               sbr_pkg::OP_TAKE_B: begin
                  in_ff[c] <= in_ff[c] + sbr_pkg::EDGE_W'(src_q[8*c +: 8]);
                  w_ff[c] <= w_ff[c] + sbr_pkg::SUM_W'(in_ff[c])
                             + sbr_pkg::SUM_W'(src_q[8*c +: 8]);
               end
               sbr_pkg::OP_TAKE_C: begin
                  // The new centre moves from the incoming to the outgoing half.
                  out_ff[c] <= out_ff[c] + sbr_pkg::EDGE_W'(src_q[8*c +: 8]);
                  in_ff[c] <= in_ff[c] - sbr_pkg::EDGE_W'(src_q[8*c +: 8]);
               end
               default: ;
            endcase
         end
         if (cmd.op == sbr_pkg::OP_CLEAR) begin
            divisor_ff <= divisor_in;
         end
      end
   end

   assign host_rd_data = img_q;

endmodule

/* src/stack_blur_rgba.sv */
// Top level of the stack blur frame store: ports, configuration and request handling.
// Depends on sbr_pkg, sbr_ctrl and sbr_dp.
//
//   channel   ports   direction   handshake
//   request   req_*   in          req_valid / req_stall
//   response  rsp_*   out         rsp_valid / rsp_stall
//   csr       csr_*   in          csr_write, no wait
//
// A load is written when it is accepted; a read passes a pending register and then
// the response register before it is answered. A blur run fills the window for each
// line, then per pixel and pass waits on the divider and each memory's single read port.
// Requests stall during a run, while a read is in flight and while a response waits.
// Reset is synchronous; the frame memories are not cleared.
module stack_blur_rgba #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_RADIUS = 254
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_pixel_index,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_alpha,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_index,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_alpha,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int MAXL = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int LW = $clog2(MAXL + 1);
   localparam int AW = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;

   logic [8:0] width_ff;
   logic [8:0] height_ff;
   logic [7:0] radius_ff;

   logic [WW-1:0] eff_w;
   logic [HW-1:0] eff_h;
   logic [7:0]    eff_r;
   logic [31:0]   count;
   logic          in_range;
   logic          req_acc;

   logic                      busy;
   logic                      div_done;
   sbr_pkg::dp_cmd_type       cmd;
   logic [LW-1:0]             pos;
   logic [LW-1:0]             line;
   logic [sbr_pkg::TAP_W-1:0] wgt;
   logic [sbr_pkg::PIX_W-1:0] host_rd_data;

   logic        pend_ff;
   logic        pend_zero_ff;
   logic [15:0] pend_idx_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_idx_ff;
   logic [31:0] rsp_pix_ff;

   always_comb begin
      eff_w = (width_ff == 9'd0) ? WW'(1)
            : (32'(width_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_ff);
      eff_h = (height_ff == 9'd0) ? HW'(1)
            : (32'(height_ff) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_ff);
      eff_r = (32'(radius_ff) > MAX_RADIUS) ? 8'(MAX_RADIUS) : radius_ff;
      count = 32'(eff_w) * 32'(eff_h);
      in_range = 32'(req_pixel_index) < count;
   end

   assign req_stall = busy | pend_ff | (rsp_valid_ff & rsp_stall);
   assign req_acc = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256;
         height_ff <= 9'd256;
         radius_ff <= 8'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            sbr_pkg::CSR_WIDTH: width_ff <= csr_data;
            sbr_pkg::CSR_HEIGHT: height_ff <= csr_data;
            sbr_pkg::CSR_RADIUS: radius_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   sbr_ctrl #(.LW(LW), .WW(WW), .HW(HW)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (req_acc && req_action == sbr_pkg::ACT_RUN),
      .eff_w    (eff_w),
      .eff_h    (eff_h),
      .eff_r    (eff_r),
      .div_done (div_done),
      .busy     (busy),
      .cmd      (cmd),
      .pos      (pos),
      .line     (line),
      .wgt      (wgt)
   );

   sbr_dp #(.LW(LW), .WW(WW), .AW(AW)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .pos          (pos),
      .line         (line),
      .wgt          (wgt),
      .eff_w        (eff_w),
      .eff_r        (eff_r),
      .host_wr_en   (req_acc && req_action == sbr_pkg::ACT_LOAD && in_range),
      .host_addr    (AW'(req_pixel_index)),
      .host_wr_data ({req_alpha, req_red, req_green, req_blue}),
      .host_rd_data (host_rd_data),
      .div_done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= req_acc && req_action == sbr_pkg::ACT_READ;
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pend_idx_ff <= req_pixel_index;
         pend_zero_ff <= ~in_range;
      end
      if (pend_ff) begin
         rsp_idx_ff <= pend_idx_ff;
         rsp_pix_ff <= pend_zero_ff ? '0 : host_rd_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_index = rsp_idx_ff;
   assign rsp_out_blue = rsp_pix_ff[7:0];
   assign rsp_out_green = rsp_pix_ff[15:8];
   assign rsp_out_red = rsp_pix_ff[23:16];
   assign rsp_out_alpha = rsp_pix_ff[31:24];

endmodule

/* src/sbr_checker.sv */
// Port-level checks for the stack blur frame store, bound to the top level.
// Depends on sbr_pkg and stack_blur_rgba.
module sbr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_action,
   input logic [15:0] req_pixel_index,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_out_index
);

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   // A response that is held back keeps its content.
   held_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_index))
      else $error("stalled response changed");

   // Every read request is answered, via the pending and response registers, with its own index.
   read_answer: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_action == sbr_pkg::ACT_READ
      |-> ##2 rsp_valid && rsp_out_index == $past(req_pixel_index, 2))
      else $error("read request not answered in time");

   // Loads, runs and unused codes never produce a response.
   no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_action != sbr_pkg::ACT_READ && !rsp_valid |=> !rsp_valid)
      else $error("response without a read request");

   after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind stack_blur_rgba sbr_checker u_sbr_checker (.*);

/* dv/tb_stack_blur_rgba.sv */
// Self-checking testbench for stack_blur_rgba: loads small frames, runs the blur, reads back.
// Depends on sbr_pkg and the stack_blur_rgba RTL; predicts results with a direct weighted sum.
module tb_stack_blur_rgba;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam int IDLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1150;

   typedef struct packed {
      logic [15:0] index;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  alpha;
   } pixel_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [15:0] req_pixel_index;
   logic [7:0]  req_blue, req_green, req_red, req_alpha;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_out_index;
   logic [7:0]  rsp_out_blue, rsp_out_green, rsp_out_red, rsp_out_alpha;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [8:0]  csr_data;

   stack_blur_rgba dut (.*);

   // Mirror of the frame store and configuration.
   logic [31:0] frame_mem [0:65535];
   logic [31:0] row_mem [0:65535];
   logic [8:0]  cfg_width, cfg_height;
   logic [7:0]  cfg_radius;
   pixel_rsp_type pending_reads [$];

   int  failures = 0;
   int  item_count = 0;
   int  idle_cycles = 0;
   int  rsp_hold = 0;
   int  stall_run = 0;
   bit  calm = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic int frame_w();
      if (cfg_width == 0) return 1;
      return cfg_width > 256 ? 256 : int'(cfg_width);
   endfunction

   function automatic int frame_h();
      if (cfg_height == 0) return 1;
      return cfg_height > 256 ? 256 : int'(cfg_height);
   endfunction

   function automatic int frame_count();
      return frame_w() * frame_h();
   endfunction

   // Blur one line straight from the definition: triangle weights, clamped edges.
   function automatic void blur_line_direct(bit to_rows, int base, int step, int n, int r);
      int s, p;
      logic [31:0] px;
      for (int k = 0; k < n; k++) begin
         px = '0;
         for (int c = 0; c < sbr_pkg::CHAN_N; c++) begin
            s = 0;
            for (int i = -r; i <= r; i++) begin
               p = k + i;
               if (p < 0) p = 0;
               if (p > n - 1) p = n - 1;
               s += (r + 1 - (i < 0 ? -i : i)) *
                    int'(to_rows ? frame_mem[base + p * step][8*c +: 8]
                                 : row_mem[base + p * step][8*c +: 8]);
            end
            px[8*c +: 8] = 8'(s / ((r + 1) * (r + 1)));
         end
         if (to_rows) row_mem[base + k * step] = px;
         else frame_mem[base + k * step] = px;
      end
   endfunction

   function automatic void blur_frame();
      int w, h, r;
      w = frame_w();
      h = frame_h();
      // Radii above the largest supported one act as that maximum.
      r = cfg_radius > 254 ? 254 : int'(cfg_radius);
      if (r == 0) return;
      for (int y = 0; y < h; y++) blur_line_direct(1, y * w, 1, w, r);
      for (int x = 0; x < w; x++) blur_line_direct(0, x, w, h, r);
   endfunction

   function automatic void apply_request(logic [1:0] act, logic [15:0] idx, logic [31:0] px);
      pixel_rsp_type e;
      case (act)
         sbr_pkg::ACT_LOAD: begin
            if (idx < frame_count()) begin
               frame_mem[idx] = px;
            end
         end
         sbr_pkg::ACT_RUN: blur_frame();
         sbr_pkg::ACT_READ: begin
            e.index = idx;
            {e.alpha, e.red, e.green, e.blue} = idx < frame_count() ? frame_mem[idx] : '0;
            pending_reads.push_back(e);
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int k;
      if (calm) return 0;
      k = $urandom_range(99);
      if (k < 70) return 0;
      if (k < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic send_request(logic [1:0] act, logic [15:0] idx, logic [31:0] px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1;
      req_action <= act;
      req_pixel_index <= idx;
      {req_alpha, req_red, req_green, req_blue} <= px;
      do @(posedge clock); while (req_stall);
      apply_request(act, idx, px);
      if (act != ACT_IGNORED && !(act == sbr_pkg::ACT_LOAD && idx >= frame_count()))
         item_count++;
   endtask

   // Wait until every read has answered, then let a trailing load finish.
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [8:0] value);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         sbr_pkg::CSR_WIDTH: cfg_width = value;
         sbr_pkg::CSR_HEIGHT: cfg_height = value;
         sbr_pkg::CSR_RADIUS: cfg_radius = value[7:0];
         default: ;
      endcase
   endtask

   task automatic set_frame(int w, int h, int r);
      drain();
      write_reg(sbr_pkg::CSR_WIDTH, 9'(w));
      write_reg(sbr_pkg::CSR_HEIGHT, 9'(h));
      write_reg(sbr_pkg::CSR_RADIUS, 9'(r));
   endtask

   task automatic load_frame(bit noisy);
      int k;
      for (int i = 0; i < frame_count(); i++) begin
         if (noisy) begin
            k = $urandom_range(99);
            if (k < 4) send_request(ACT_IGNORED, 16'($urandom), $urandom);
            else if (k < 8)
               send_request(sbr_pkg::ACT_LOAD,
                            16'($urandom_range(65535, frame_count())), $urandom);
            else if (k < 12)
               send_request(sbr_pkg::ACT_READ,
                            16'($urandom_range(65535, frame_count())), $urandom);
         end
         send_request(sbr_pkg::ACT_LOAD, 16'(i), $urandom);
      end
   endtask

   task automatic read_some(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0)
            send_request(sbr_pkg::ACT_READ,
                         16'($urandom_range(65535, frame_count())), $urandom);
         else
            send_request(sbr_pkg::ACT_READ, 16'($urandom_range(frame_count() - 1)), $urandom);
      end
   endtask

   task automatic test_directed_frame();
      logic [31:0] corner [6] = '{32'h0, 32'hFFFF_FFFF, 32'hFF00_FF00, 32'h00FF_00FF,
                                  32'h8040_2010, 32'h0102_0408};
      set_frame(3, 2, 1);
      for (int i = 0; i < 6; i++) send_request(sbr_pkg::ACT_LOAD, 16'(i), corner[i]);
      send_request(sbr_pkg::ACT_LOAD, 16'd6, 32'h1234_5678);
      send_request(sbr_pkg::ACT_LOAD, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(ACT_IGNORED, 16'd0, 32'hFFFF_FFFF);
      send_request(sbr_pkg::ACT_READ, 16'd1, '0);
      send_request(sbr_pkg::ACT_RUN, 16'd0, '0);
      for (int i = 0; i < 6; i++) send_request(sbr_pkg::ACT_READ, 16'(i), '0);
      send_request(sbr_pkg::ACT_READ, 16'hFFFF, '0);
      send_request(sbr_pkg::ACT_READ, 16'd6, '0);
   endtask

   task automatic test_config_edges();
      // Zero width and height both act as one, so a single pixel is in use.
      set_frame(0, 0, 254);
      send_request(sbr_pkg::ACT_LOAD, 16'd0, 32'hA5C3_7E01);
      send_request(sbr_pkg::ACT_RUN, 16'd0, '0);
      send_request(sbr_pkg::ACT_READ, 16'd0, '0);
      send_request(sbr_pkg::ACT_READ, 16'd1, '0);
      set_frame(4, 3, 0);
      load_frame(0);
      send_request(sbr_pkg::ACT_RUN, 16'd0, '0);
      read_some(4);
      set_frame(5, 4, 255);
      load_frame(0);
      send_request(sbr_pkg::ACT_RUN, 16'd0, '0);
      read_some(6);
   endtask

   task automatic test_backpressure();
      set_frame(4, 4, 2);
      load_frame(0);
      send_request(sbr_pkg::ACT_RUN, 16'd0, '0);
      @(negedge clock);
      rsp_hold = 400;
      calm = 1;
      read_some(30);
      calm = 0;
      drain();
   endtask

   task automatic test_random_frames();
      int w, h, r, k, start;
      start = item_count;
      while (item_count - start < RANDOM_ITEMS) begin
         k = $urandom_range(99);
         if (k < 6) begin
            // Long rows or columns, up to and past the store's reach, small radius.
            w = $urandom_range(1) ? $urandom_range(511, 200) : 1;
            h = w == 1 ? $urandom_range(511, 200) : $urandom_range(1, 0);
            r = $urandom_range(4);
         end else begin
            w = $urandom_range(12);
            h = $urandom_range(12);
            r = $urandom_range(9) == 0 ? $urandom_range(254, 100) : $urandom_range(6);
         end
         calm = $urandom_range(5) == 0;
         set_frame(w, h, r);
         load_frame(1);
         send_request(sbr_pkg::ACT_RUN, 16'($urandom), $urandom);
         if ($urandom_range(4) == 0) send_request(sbr_pkg::ACT_RUN, 16'($urandom), $urandom);
         read_some($urandom_range(20, 4));
      end
      calm = 0;
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on %s: got %0h, expected %0h", field, got, want);
      failures++;
   endtask

   // Response side: random holds of mixed length, with quiet stretches.
   initial begin
      int k;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_stall <= 1;
            rsp_hold--;
         end else if (stall_run > 0) begin
            stall_run--;
         end else if (calm) begin
            rsp_stall <= 0;
            stall_run = 8;
         end else begin
            k = $urandom_range(99);
            if (k < 55) begin
               rsp_stall <= 0;
               stall_run = $urandom_range(12, 1);
            end else if (k < 90) begin
               rsp_stall <= 1;
               stall_run = $urandom_range(2);
            end else begin
               rsp_stall <= 1;
               stall_run = $urandom_range(50, 10);
            end
         end
      end
   end

   always @(posedge clock) begin
      pixel_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            report_mismatch("response with no read outstanding, index", rsp_out_index, 0);
         end else begin
            e = pending_reads.pop_front();
            if (rsp_out_index !== e.index) report_mismatch("index", rsp_out_index, e.index);
            if (rsp_out_blue !== e.blue) report_mismatch("blue", rsp_out_blue, e.blue);
            if (rsp_out_green !== e.green) report_mismatch("green", rsp_out_green, e.green);
            if (rsp_out_red !== e.red) report_mismatch("red", rsp_out_red, e.red);
            if (rsp_out_alpha !== e.alpha) report_mismatch("alpha", rsp_out_alpha, e.alpha);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("stack_blur_rgba test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_action = sbr_pkg::ACT_LOAD;
      req_pixel_index = '0;
      {req_alpha, req_red, req_green, req_blue} = '0;
      csr_write = 0;
      csr_index = sbr_pkg::CSR_WIDTH;
      csr_data = '0;
      cfg_width = 256;
      cfg_height = 256;
      cfg_radius = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed_frame();
      test_config_edges();
      test_backpressure();
      test_random_frames();
      drain();
      repeat (20) @(posedge clock);
      if (failures == 0 && pending_reads.size() == 0) begin
         $display("stack_blur_rgba test passed");
      end else begin
         $display("stack_blur_rgba test failed");
      end
      $finish;
   end

endmodule
